// File: hw/rtl/rrvw_pkg.sv
// shared types and constants for the roller ram video walker
package rrvw_pkg;

    localparam int FRAME_ROWS   = 256;
    localparam int ROW_BYTES    = 90;
    localparam int VISIBLE_60HZ = 200;

    localparam int ADDR_W  = 18;
    localparam int ROW_W   = 8;
    localparam int COL_W   = 7;
    localparam int CODES_W = 32;

    localparam logic [CODES_W-1:0] FG_CODES = 32'h1111_1111;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_CELL = 1'b1;

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    localparam logic [2:0] CFG_TABLE_BASE   = 3'd0;
    localparam logic [2:0] CFG_SCROLL       = 3'd1;
    localparam logic [2:0] CFG_INVERT       = 3'd2;
    localparam logic [2:0] CFG_SHORT_FRAME  = 3'd3;
    localparam logic [2:0] CFG_PIXEL_MODE   = 3'd4;
    localparam logic [2:0] CFG_DISPLAY_ON   = 3'd5;
    localparam logic [2:0] CFG_TABLE_PROG   = 3'd6;
    localparam logic [2:0] CFG_SCREEN_GATE  = 3'd7;

    localparam logic [1:0] MODE_MONO = 2'd0;
    localparam logic [1:0] MODE_QUAD = 2'd3;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_FRAME_FG = 3'd1,
        PH_FRAME_BG = 3'd2,
        PH_ROW_BG   = 3'd3,
        PH_ROW_FG   = 3'd4,
        PH_TBL_LO   = 3'd5,
        PH_TBL_HI   = 3'd6,
        PH_PIXEL    = 3'd7
    } t_phase;

    typedef struct packed {
        logic [7:0] table_base;
        logic [7:0] scroll;
        logic       invert;
        logic       short_frame;
        logic [1:0] pixel_mode;
        logic       display_on;
        logic       table_prog;
        logic       screen_gate;
    } t_cfg;

    typedef struct packed {
        logic               kind;
        logic [ADDR_W-1:0]  read_address;
        logic [CODES_W-1:0] pixel_codes;
        logic               codes_are_palette;
        logic [ROW_W-1:0]   cell_row;
        logic [COL_W-1:0]   cell_column;
        logic               frame_end;
        logic               last;
    } t_result;

    // up to two results written into the output queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// File: hw/rtl/rrvw_walker.sv
// input register, walk state and per-request step logic
module rrvw_walker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrvw_pkg::t_cfg                i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_op,
    input  logic [7:0]                    i_mem_byte,
    input  logic                          i_byte_was_written,
    input  logic [rrvw_pkg::FIFO_CW-1:0]  i_free,
    output rrvw_pkg::t_push               o_push
);
    import rrvw_pkg::*;

    logic              r_in_valid;
    logic [1:0]        r_op;
    logic [7:0]        r_byte;
    logic              r_wr;

    t_phase            r_phase, n_phase;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [7:0]        r_lo_byte, n_lo_byte;
    logic              r_lo_wr, n_lo_wr;
    logic [ADDR_W-1:0] r_src, n_src;

    logic              advance;
    logic              row_end, frame_end;
    logic [ROW_W-1:0]  next_row;
    logic [COL_W-1:0]  next_col;
    logic              do_cell, cell_fetched, cell_pal;
    logic [CODES_W-1:0] cell_codes, dec_codes;
    logic [15:0]       word;
    t_result           res0, res1;
    logic [1:0]        cnt;

    function automatic logic [ADDR_W-1:0] table_addr(input logic [7:0] tb,
                                                     input logic [7:0] scroll,
                                                     input logic [ROW_W-1:0] row);
        logic [ADDR_W-1:0] base;
        logic [7:0]        idx;
        base = {1'b0, tb[7:5], tb[4:0], 9'b0};
        idx  = 8'(row + scroll);
        return base + {9'b0, idx, 1'b0};
    endfunction

    function automatic logic past_visible(input logic short_frame,
                                          input logic [ROW_W-1:0] row);
        if (short_frame)
            return {1'b0, row} >= 9'(VISIBLE_60HZ);
        return {1'b0, row} >= 9'(FRAME_ROWS);
    endfunction

    function automatic t_result make_read(input logic [ADDR_W-1:0] addr,
                                          input logic [ROW_W-1:0] row,
                                          input logic [COL_W-1:0] col);
        t_result r;
        r = '0;
        r.kind         = KIND_READ;
        r.read_address = addr;
        r.cell_row     = row;
        r.cell_column  = col;
        return r;
    endfunction

    function automatic logic [CODES_W-1:0] decode(input logic [7:0] b,
                                                  input logic [1:0] mode);
        logic [CODES_W-1:0] c;
        c = '0;
        case (mode)
            MODE_MONO: begin
                for (int i = 0; i < 8; i++)
                    c[28 - 4*i +: 4] = {3'b0, b[7 - i]};
            end
            MODE_QUAD: c = {{4{b[7:4]}}, {4{b[3:0]}}};
            default: begin
                // two-bit indices, each shown twice
                for (int i = 0; i < 4; i++)
                    c[24 - 8*i +: 8] = {2'b0, b[7 - 2*i -: 2], 2'b0, b[7 - 2*i -: 2]};
            end
        endcase
        return c;
    endfunction

    assign advance    = r_in_valid && (i_free >= FIFO_CW'(2));
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_op   <= i_op;
            r_byte <= i_mem_byte;
            r_wr   <= i_byte_was_written;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_row     <= '0;
            r_col     <= '0;
            r_lo_byte <= '0;
            r_lo_wr   <= 1'b0;
            r_src     <= '0;
        end else if (advance) begin
            r_phase   <= n_phase;
            r_row     <= n_row;
            r_col     <= n_col;
            r_lo_byte <= n_lo_byte;
            r_lo_wr   <= n_lo_wr;
            r_src     <= n_src;
        end
    end

    assign row_end   = (8'(r_col) + 8'd1) >= 8'(ROW_BYTES);
    assign frame_end = row_end && ((9'(r_row) + 9'd1) >= 9'(FRAME_ROWS));
    assign next_row  = r_row + ROW_W'(1);
    assign next_col  = r_col + COL_W'(1);
    assign word      = {r_byte, r_lo_byte};
    assign dec_codes = decode(r_byte ^ {8{i_cfg.invert}}, i_cfg.pixel_mode);

    always_comb begin
        n_phase      = r_phase;
        n_row        = r_row;
        n_col        = r_col;
        n_lo_byte    = r_lo_byte;
        n_lo_wr      = r_lo_wr;
        n_src        = r_src;
        res0         = '0;
        res1         = '0;
        cnt          = 2'd0;
        do_cell      = 1'b0;
        cell_fetched = 1'b0;
        cell_pal     = 1'b0;
        cell_codes   = '0;

        case (r_op)
            OP_START: begin
                n_row = '0;
                n_col = '0;
                if (!i_cfg.display_on || !i_cfg.table_prog) begin
                    n_phase = PH_FRAME_FG;
                end else if (!i_cfg.screen_gate) begin
                    n_phase = PH_FRAME_BG;
                end else if (past_visible(i_cfg.short_frame, '0)) begin
                    n_phase = PH_ROW_BG;
                end else begin
                    n_phase = PH_TBL_LO;
                    res0 = make_read(table_addr(i_cfg.table_base, i_cfg.scroll, '0),
                                     '0, '0);
                    cnt  = 2'd1;
                end
            end
            OP_BYTE: begin
                case (r_phase)
                    PH_TBL_LO: begin
                        n_lo_byte = r_byte;
                        n_lo_wr   = r_wr;
                        n_phase   = PH_TBL_HI;
                        res0 = make_read(table_addr(i_cfg.table_base, i_cfg.scroll, r_row)
                                         + ADDR_W'(1), r_row, r_col);
                        cnt  = 2'd1;
                    end
                    PH_TBL_HI: begin
                        n_col = '0;
                        if (r_lo_wr && r_wr) begin
                            // roller word to row address, bit 3 stays clear
                            n_src   = {1'b0, word[15:3], 1'b0, word[2:0]};
                            n_phase = PH_PIXEL;
                            res0    = make_read({1'b0, word[15:3], 1'b0, word[2:0]},
                                                r_row, '0);
                            cnt     = 2'd1;
                        end else begin
                            n_phase = PH_ROW_FG;
                        end
                    end
                    PH_PIXEL: begin
                        do_cell      = 1'b1;
                        cell_fetched = 1'b1;
                        cell_codes   = r_wr ? dec_codes : FG_CODES;
                        cell_pal     = r_wr && (i_cfg.pixel_mode != MODE_MONO);
                    end
                    default: ;
                endcase
            end
            OP_TICK: begin
                case (r_phase)
                    PH_FRAME_FG, PH_ROW_FG: begin
                        do_cell    = 1'b1;
                        cell_codes = FG_CODES;
                    end
                    PH_FRAME_BG, PH_ROW_BG: begin
                        do_cell = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (do_cell) begin
            res0.kind              = KIND_CELL;
            res0.pixel_codes       = cell_codes;
            res0.codes_are_palette = cell_pal;
            res0.cell_row          = r_row;
            res0.cell_column       = r_col;
            res0.frame_end         = frame_end;
            cnt                    = 2'd1;
            if (frame_end) begin
                n_phase = PH_IDLE;
                n_row   = '0;
                n_col   = '0;
            end else if (row_end) begin
                n_row = next_row;
                n_col = '0;
                if (r_phase == PH_FRAME_FG || r_phase == PH_FRAME_BG) begin
                    n_phase = r_phase;
                end else if (past_visible(i_cfg.short_frame, next_row)) begin
                    n_phase = PH_ROW_BG;
                end else begin
                    n_phase = PH_TBL_LO;
                    res1 = make_read(table_addr(i_cfg.table_base, i_cfg.scroll, next_row),
                                     next_row, '0);
                    cnt  = 2'd2;
                end
            end else begin
                n_col = next_col;
                if (cell_fetched) begin
                    res1 = make_read(r_src + ADDR_W'({next_col, 3'b000}), r_row, next_col);
                    cnt  = 2'd2;
                end
            end
        end

        if (cnt == 2'd2)
            res1.last = 1'b1;
        else if (cnt == 2'd1)
            res0.last = 1'b1;
    end

    assign o_push.count = advance ? cnt : 2'd0;
    assign o_push.r0    = res0;
    assign o_push.r1    = res1;

    a_idle_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_row == '0 && r_col == '0)
        else $error("idle walker left away from the first cell");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        8'(r_col) < 8'(ROW_BYTES))
        else $error("column counter ran past the row");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.count != 2'd0 |-> i_free >= FIFO_CW'(o_push.count))
        else $error("result pushed without queue room");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_valid && $stable(r_op) && $stable(r_byte))
        else $error("held request changed while stalled");

endmodule

// File: hw/rtl/rrvw_out_fifo.sv
// result queue taking up to two results per cycle and giving out one while the receiver does not stall
module rrvw_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrvw_pkg::t_push               i_push,
    output logic [rrvw_pkg::FIFO_CW-1:0]  o_free,
    output logic                          o_valid,
    input  logic                          i_stall,
    output rrvw_pkg::t_result             o_result
);
    import rrvw_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_head, n_head;
    logic [FIFO_AW-1:0]   r_tail, n_tail;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic                 pop;
    logic [FIFO_AW-1:0]   tail_next;

    assign pop       = (r_count != '0) && !i_stall;
    assign tail_next = r_tail + FIFO_AW'(1);
    assign n_head    = pop ? r_head + FIFO_AW'(1) : r_head;
    assign n_tail    = r_tail + FIFO_AW'(i_push.count);
    assign n_count   = r_count + FIFO_CW'(i_push.count) - FIFO_CW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0)
            r_mem[r_tail] <= i_push.r0;
        if (i_push.count == 2'd2)
            r_mem[tail_next] <= i_push.r1;
    end

    assign o_free   = FIFO_CW'(FIFO_DEPTH) - r_count;
    assign o_valid  = r_count != '0;
    assign o_result = r_mem[r_head];

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_pop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_push.count == 2'd0 |=> r_count == $past(r_count) - FIFO_CW'(1))
        else $error("queue count lost track of a pop");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != FIFO_CW'(FIFO_DEPTH) && r_count != '0 |-> r_head != r_tail)
        else $error("queue pointers disagree with count");

endmodule

// File: hw/rtl/roller_ram_video_walker_core.sv
// top level of the roller ram video walker: config registers, walker and result queue
//
// Requests enter on the input channel (i_in_valid / o_in_stall): op 0 starts a
// frame, op 1 returns the byte for the last read request, op 2 is a fill tick.
// Results leave on the output channel (o_out_valid / i_out_stall): o_kind 0 is
// a read request carrying o_read_address, o_kind 1 is an eight-pixel cell;
// o_last marks the final result a request caused. A request gives 0, 1 or 2
// results.
// An accepted request is held in the input register and processed from
// there; its results are written into the result queue and show on the
// output from the queue head. One request is taken per cycle as long as the
// four-entry result queue has room for two more results.
// Requests giving at most one result run at one per cycle while the receiver
// does not stall; a steady stream of two-result requests runs slower, held
// back by the output port giving out one result per cycle.
// When the receiver stalls, results wait in the queue and the head holds
// steady; once fewer than two slots are free the input stalls.
// Reset (i_rst_n low, synchronous) clears the config registers, the walk
// state and the queue; the block comes up idle with no frame under way.
// Config writes (i_cfg_we) take effect at the edge and belong to idle times.
module roller_ram_video_walker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_mem_byte,
    input  logic        i_byte_was_written,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [17:0] o_read_address,
    output logic [31:0] o_pixel_codes,
    output logic        o_codes_are_palette,
    output logic [7:0]  o_cell_row,
    output logic [6:0]  o_cell_column,
    output logic        o_frame_end,
    output logic        o_last
);
    import rrvw_pkg::*;

    t_cfg                r_cfg;
    t_push               push;
    logic [FIFO_CW-1:0]  free;
    t_result             result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TABLE_BASE:  r_cfg.table_base  <= i_cfg_data;
                CFG_SCROLL:      r_cfg.scroll      <= i_cfg_data;
                CFG_INVERT:      r_cfg.invert      <= i_cfg_data[0];
                CFG_SHORT_FRAME: r_cfg.short_frame <= i_cfg_data[0];
                CFG_PIXEL_MODE:  r_cfg.pixel_mode  <= i_cfg_data[1:0];
                CFG_DISPLAY_ON:  r_cfg.display_on  <= i_cfg_data[0];
                CFG_TABLE_PROG:  r_cfg.table_prog  <= i_cfg_data[0];
                CFG_SCREEN_GATE: r_cfg.screen_gate <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    rrvw_walker u_walker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_op               (i_op),
        .i_mem_byte         (i_mem_byte),
        .i_byte_was_written (i_byte_was_written),
        .i_free             (free),
        .o_push             (push)
    );

    rrvw_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_free   (free),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (result)
    );

    assign o_kind              = result.kind;
    assign o_read_address      = result.read_address;
    assign o_pixel_codes       = result.pixel_codes;
    assign o_codes_are_palette = result.codes_are_palette;
    assign o_cell_row          = result.cell_row;
    assign o_cell_column       = result.cell_column;
    assign o_frame_end         = result.frame_end;
    assign o_last              = result.last;

endmodule

// File: test/tb_roller_ram_video_walker_core.sv
// self-checking testbench for the roller ram video walker core
module tb_roller_ram_video_walker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rrvw_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = OP_START;
    logic [7:0]  i_mem_byte = '0;
    logic        i_byte_was_written = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_kind;
    logic [17:0] o_read_address;
    logic [31:0] o_pixel_codes;
    logic        o_codes_are_palette;
    logic [7:0]  o_cell_row;
    logic [6:0]  o_cell_column;
    logic        o_frame_end;
    logic        o_last;

    roller_ram_video_walker_core uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_op                (i_op),
        .i_mem_byte          (i_mem_byte),
        .i_byte_was_written  (i_byte_was_written),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_kind              (o_kind),
        .o_read_address      (o_read_address),
        .o_pixel_codes       (o_pixel_codes),
        .o_codes_are_palette (o_codes_are_palette),
        .o_cell_row          (o_cell_row),
        .o_cell_column       (o_cell_column),
        .o_frame_end         (o_frame_end),
        .o_last              (o_last)
    );

    always #10 i_clk = ~i_clk;

    // walker shadow state and register copy
    t_cfg        cfg_now = '0;
    t_phase      walk_ph = PH_IDLE;
    logic [7:0]  row_ctr = '0;
    logic [6:0]  col_ctr = '0;
    logic [7:0]  roller_lo = '0;
    logic        roller_lo_wr = 1'b0;
    logic [17:0] row_src = '0;
    t_result     pending_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned cycle_count = 0;
    int unsigned requests_sent = 0;
    int unsigned results_checked = 0;
    int unsigned cells_seen = 0;
    int unsigned frames_ended = 0;
    int unsigned fail_count = 0;

    function automatic logic [17:0] roller_slot_addr();
        logic [17:0] base;
        logic [7:0]  slot;
        base = {1'b0, cfg_now.table_base[7:5], cfg_now.table_base[4:0], 9'd0};
        slot = row_ctr + cfg_now.scroll;
        return base + {slot, 1'b0};
    endfunction

    function automatic void queue_result(logic kind, logic [17:0] addr, logic [31:0] codes,
                                         logic pal, logic fend);
        t_result r;
        r.kind = kind;
        r.read_address = addr;
        r.pixel_codes = codes;
        r.codes_are_palette = pal;
        r.cell_row = row_ctr;
        r.cell_column = col_ctr;
        r.frame_end = fend;
        r.last = 1'b0;
        pending_results.push_back(r);
    endfunction

    function automatic void start_row();
        col_ctr = '0;
        if (walk_ph == PH_FRAME_FG || walk_ph == PH_FRAME_BG)
            return;
        if (cfg_now.short_frame && row_ctr >= VISIBLE_60HZ) begin
            walk_ph = PH_ROW_BG;
            return;
        end
        walk_ph = PH_TBL_LO;
        queue_result(KIND_READ, roller_slot_addr(), '0, 1'b0, 1'b0);
    endfunction

    function automatic void put_cell(logic [31:0] codes, logic pal, logic fetched);
        logic row_end;
        logic fend;
        row_end = (int'(col_ctr) + 1 >= ROW_BYTES);
        fend = row_end && (int'(row_ctr) + 1 >= FRAME_ROWS);
        queue_result(KIND_CELL, '0, codes, pal, fend);
        if (fend) begin
            walk_ph = PH_IDLE;
            row_ctr = '0;
            col_ctr = '0;
        end else if (row_end) begin
            row_ctr = row_ctr + 8'd1;
            start_row();
        end else begin
            col_ctr = col_ctr + 7'd1;
            if (fetched)
                queue_result(KIND_READ, row_src + {col_ctr, 3'b000}, '0, 1'b0, 1'b0);
        end
    endfunction

    // advance the shadow walker by one accepted request
    function automatic void walk_step(logic [1:0] op, logic [7:0] b, logic wr);
        int          prior_size;
        int          i;
        logic [15:0] word;
        logic [7:0]  pix;
        logic [31:0] codes;
        t_result     tail;
        prior_size = pending_results.size();
        case (op)
            OP_START: begin
                row_ctr = '0;
                col_ctr = '0;
                if (!cfg_now.display_on || !cfg_now.table_prog)
                    walk_ph = PH_FRAME_FG;
                else if (!cfg_now.screen_gate)
                    walk_ph = PH_FRAME_BG;
                else
                    walk_ph = PH_IDLE;
                start_row();
            end
            OP_BYTE: begin
                if (walk_ph == PH_TBL_LO) begin
                    roller_lo = b;
                    roller_lo_wr = wr;
                    walk_ph = PH_TBL_HI;
                    queue_result(KIND_READ, roller_slot_addr() + 18'd1, '0, 1'b0, 1'b0);
                end else if (walk_ph == PH_TBL_HI) begin
                    col_ctr = '0;
                    if (roller_lo_wr && wr) begin
                        word = {b, roller_lo};
                        row_src = {1'b0, word[15:13], word[12:3], 1'b0, word[2:0]};
                        walk_ph = PH_PIXEL;
                        queue_result(KIND_READ, row_src, '0, 1'b0, 1'b0);
                    end else begin
                        walk_ph = PH_ROW_FG;
                    end
                end else if (walk_ph == PH_PIXEL) begin
                    if (wr) begin
                        pix = cfg_now.invert ? ~b : b;
                        codes = '0;
                        if (cfg_now.pixel_mode == MODE_MONO) begin
                            for (i = 0; i < 8; i++)
                                codes[31-4*i -: 4] = {3'b000, pix[7-i]};
                        end else if (cfg_now.pixel_mode == MODE_QUAD) begin
                            codes = {{4{pix[7:4]}}, {4{pix[3:0]}}};
                        end else begin
                            for (i = 0; i < 4; i++)
                                codes[31-8*i -: 8] = {2'b00, pix[7-2*i -: 2],
                                                      2'b00, pix[7-2*i -: 2]};
                        end
                        put_cell(codes, cfg_now.pixel_mode != MODE_MONO, 1'b1);
                    end else begin
                        put_cell(FG_CODES, 1'b0, 1'b1);
                    end
                end
            end
            OP_TICK: begin
                if (walk_ph == PH_FRAME_FG || walk_ph == PH_ROW_FG)
                    put_cell(FG_CODES, 1'b0, 1'b0);
                else if (walk_ph == PH_FRAME_BG || walk_ph == PH_ROW_BG)
                    put_cell('0, 1'b0, 1'b0);
            end
            default: ;
        endcase
        if (pending_results.size() > prior_size) begin
            tail = pending_results.pop_back();
            tail.last = 1'b1;
            pending_results.push_back(tail);
        end
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk)
        i_out_stall <= i_rst_n && ($urandom_range(0, 99) < stall_pct);

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: kind %0d addr %05h codes %08h row %0d col %0d",
                             o_kind, o_read_address, o_pixel_codes, o_cell_row, o_cell_column);
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind || o_read_address !== want.read_address ||
                    o_pixel_codes !== want.pixel_codes ||
                    o_codes_are_palette !== want.codes_are_palette ||
                    o_cell_row !== want.cell_row || o_cell_column !== want.cell_column ||
                    o_frame_end !== want.frame_end || o_last !== want.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("result %0d mismatch", results_checked);
                        $display("  expected kind %0d addr %05h codes %08h pal %0d row %0d",
                                 want.kind, want.read_address, want.pixel_codes,
                                 want.codes_are_palette, want.cell_row);
                        $display("           col %0d end %0d last %0d",
                                 want.cell_column, want.frame_end, want.last);
                        $display("  actual   kind %0d addr %05h codes %08h pal %0d row %0d",
                                 o_kind, o_read_address, o_pixel_codes,
                                 o_codes_are_palette, o_cell_row);
                        $display("           col %0d end %0d last %0d",
                                 o_cell_column, o_frame_end, o_last);
                    end
                end
            end
            results_checked++;
            if (o_kind == KIND_CELL)
                cells_seen++;
            if (o_frame_end)
                frames_ended++;
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [7:0] b, input logic wr);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_mem_byte <= b;
        i_byte_was_written <= wr;
        do @(posedge i_clk); while (o_in_stall);
        walk_step(op, b, wr);
        requests_sent++;
    endtask

    // let every expected result drain and the walker settle
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_config(input t_cfg c);
        logic [7:0] vals [8];
        int         k;
        vals[CFG_TABLE_BASE]  = c.table_base;
        vals[CFG_SCROLL]      = c.scroll;
        vals[CFG_INVERT]      = {7'b0, c.invert};
        vals[CFG_SHORT_FRAME] = {7'b0, c.short_frame};
        vals[CFG_PIXEL_MODE]  = {6'b0, c.pixel_mode};
        vals[CFG_DISPLAY_ON]  = {7'b0, c.display_on};
        vals[CFG_TABLE_PROG]  = {7'b0, c.table_prog};
        vals[CFG_SCREEN_GATE] = {7'b0, c.screen_gate};
        for (k = 0; k < 8; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= k[2:0];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_now = c;
    endtask

    // sends requests that follow the walk, with some noise mixed in
    task automatic drive_walk(input int count, input int noise_pct, input int unwritten_pct);
        int         counted;
        logic [1:0] op;
        logic [7:0] b;
        logic       wr;
        logic       fetching;
        logic       filling;
        logic       ignored;
        counted = 0;
        while (counted < count) begin
            b = 8'($urandom_range(0, 255));
            wr = ($urandom_range(0, 99) >= unwritten_pct);
            fetching = (walk_ph == PH_TBL_LO || walk_ph == PH_TBL_HI || walk_ph == PH_PIXEL);
            filling = (walk_ph == PH_FRAME_FG || walk_ph == PH_FRAME_BG ||
                       walk_ph == PH_ROW_FG || walk_ph == PH_ROW_BG);
            if ($urandom_range(0, 99) < noise_pct)
                op = 2'($urandom_range(0, 3));
            else if (fetching)
                op = OP_BYTE;
            else if (filling)
                op = OP_TICK;
            else
                op = OP_START;
            ignored = (op == OP_RESERVED) || (op == OP_BYTE && !fetching) ||
                      (op == OP_TICK && !filling);
            send_request(op, b, wr);
            if (!ignored)
                counted++;
        end
    endtask

    // reset values give a foreground frame; then the background gate
    task automatic test_fill_frames();
        t_cfg c;
        send_request(OP_START, 8'h00, 1'b0);
        send_request(OP_TICK, 8'h00, 1'b0);
        send_request(OP_TICK, 8'hFF, 1'b1);
        send_request(OP_RESERVED, 8'h55, 1'b1);
        send_request(OP_BYTE, 8'hAA, 1'b1);
        quiesce();
        c = '0;
        c.display_on = 1'b1;
        c.table_prog = 1'b1;
        apply_config(c);
        send_request(OP_START, 8'h00, 1'b0);
        send_request(OP_TICK, 8'h00, 1'b0);
        send_request(OP_TICK, 8'h00, 1'b0);
    endtask

    // fetched row at the top of the address space, all pixel modes
    task automatic test_fetched_row();
        t_cfg c;
        quiesce();
        c = '0;
        c.table_base = 8'hFF;
        c.scroll = 8'hFF;
        c.short_frame = 1'b1;
        c.pixel_mode = MODE_MONO;
        c.display_on = 1'b1;
        c.table_prog = 1'b1;
        c.screen_gate = 1'b1;
        apply_config(c);
        send_request(OP_START, 8'h00, 1'b0);
        send_request(OP_BYTE, 8'hAA, 1'b1);
        send_request(OP_BYTE, 8'hFF, 1'b1);
        send_request(OP_BYTE, 8'hFF, 1'b1);
        send_request(OP_BYTE, 8'h00, 1'b1);
        send_request(OP_BYTE, 8'h5A, 1'b0);
        send_request(OP_TICK, 8'h00, 1'b0);
        quiesce();
        c.invert = 1'b1;
        c.pixel_mode = MODE_QUAD;
        apply_config(c);
        send_request(OP_BYTE, 8'h5A, 1'b1);
        quiesce();
        c.invert = 1'b0;
        c.pixel_mode = 2'd1;
        apply_config(c);
        send_request(OP_BYTE, 8'hC3, 1'b1);
        quiesce();
        c.pixel_mode = 2'd2;
        apply_config(c);
        send_request(OP_BYTE, 8'h1E, 1'b1);
        // restart in the middle of a row
        send_request(OP_START, 8'h00, 1'b0);
    endtask

    // either roller byte unwritten turns the row into a foreground fill
    task automatic test_unwritten_table();
        send_request(OP_BYTE, 8'h12, 1'b0);
        send_request(OP_BYTE, 8'h34, 1'b1);
        send_request(OP_TICK, 8'h00, 1'b0);
        send_request(OP_START, 8'h00, 1'b0);
        send_request(OP_BYTE, 8'h00, 1'b1);
        send_request(OP_BYTE, 8'h00, 1'b0);
        send_request(OP_TICK, 8'h00, 1'b0);
    endtask

    // two whole rows, so each row end issues the next table read
    task automatic test_row_turns();
        t_cfg c;
        quiesce();
        c.table_base = 8'($urandom);
        c.scroll = 8'($urandom);
        c.invert = 1'($urandom);
        c.short_frame = 1'b1;
        c.pixel_mode = 2'($urandom);
        c.display_on = 1'b1;
        c.table_prog = 1'b1;
        c.screen_gate = 1'b1;
        apply_config(c);
        send_request(OP_START, 8'h00, 1'b0);
        while (row_ctr < 8'd2)
            drive_walk(1, 0, 2);
    endtask

    task automatic test_random_walk();
        t_cfg c;
        int   ph;
        int   chunk;
        for (ph = 0; ph < 4; ph++) begin
            for (chunk = 0; chunk < 2; chunk++) begin
                quiesce();
                case (ph)
                    0: begin send_idle_pct = 0;  stall_pct = 0;  end
                    1: begin send_idle_pct = 72; stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  stall_pct = 72; end
                    default: begin send_idle_pct = 33; stall_pct = 33; end
                endcase
                c.table_base = 8'($urandom);
                c.scroll = 8'($urandom);
                c.invert = 1'($urandom);
                c.short_frame = 1'($urandom);
                c.pixel_mode = 2'($urandom);
                c.display_on = ($urandom_range(0, 9) != 0);
                c.table_prog = ($urandom_range(0, 9) != 0);
                c.screen_gate = ($urandom_range(0, 9) != 0);
                if (ph == 0 && chunk == 0) begin
                    c.table_base = '0;
                    c.scroll = '0;
                    c.invert = 1'b0;
                    c.pixel_mode = MODE_MONO;
                end
                if (ph == 3 && chunk == 1) begin
                    c.table_base = '1;
                    c.scroll = '1;
                    c.invert = 1'b1;
                    c.pixel_mode = MODE_QUAD;
                end
                apply_config(c);
                drive_walk(120, 8, 6);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_frames();
        test_fetched_row();
        test_unwritten_table();
        test_row_turns();
        test_random_walk();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        $display("%0d requests sent, %0d results checked, %0d of them cells",
                 requests_sent, results_checked, cells_seen);
        $display("%0d frame ends seen, %0d failures, %0d cycles",
                 frames_ended, fail_count, cycle_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
